// ===== hdl/ocd_pkg.sv =====
// shared types, constants and ring arithmetic helpers for the overwriting circular deque
// no dependencies; ocd_if, ocd_step and the core import this package

package ocd_pkg;

	// storage geometry
	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;

	// field widths fixed by the transaction format
	localparam int CMD_W    = 3;
	localparam int IDX_W    = 4;
	localparam int CFG_W    = 5;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// derived widths
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = ((PTR_W > IDX_W) ? PTR_W : IDX_W) + 1;

	localparam int CAP_RESET = 16;

	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [DATA_W-1:0]   data_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CMD_W-1:0]    cmd_code_t;
	typedef logic [CFG_W-1:0]    cfg_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_READ_IDX   = 3'd4,
		CMD_WRITE_IDX  = 3'd5,
		CMD_CLEAR      = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_RANGE_ERR = 2'd1,
		ST_EMPTY_ERR = 2'd2
	} status_t;

	// pointer and fill state of the ring
	typedef struct packed {
		ptr_t head;
		ptr_t tail;
		cnt_t count;
	} ring_state_t;

	// one slot write
	typedef struct packed {
		logic  en;
		ptr_t  addr;
		data_t data;
	} slot_wr_t;

	// everything that goes into one result transaction
	typedef struct packed {
		data_t   read_value;
		cnt_t    count;
		logic    is_empty;
		logic    is_full;
		logic    overwrote;
		status_t status;
	} result_t;

	// capacity register value as used by the ring: zero acts as one, above depth acts as depth
	function automatic cnt_t eff_cap(cfg_t raw);
		int unsigned r;
		r = int'(raw);
		if (r == 0)
			return cnt_t'(1);
		else if (r > DEPTH)
			return cnt_t'(DEPTH);
		else
			return cnt_t'(r);
	endfunction

	function automatic ptr_t ring_next(ptr_t p, cnt_t cap);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(p) + (CNT_W+1)'(1);
		return (s >= (CNT_W+1)'(cap)) ? '0 : PTR_W'(s);
	endfunction

	function automatic ptr_t ring_prev(ptr_t p, cnt_t cap);
		return (p == '0) ? PTR_W'(cap - cnt_t'(1)) : p - ptr_t'(1);
	endfunction

	// logical position counted from the head to physical slot, wrapped at the capacity
	function automatic ptr_t slot_pos(ptr_t head, idx_t index, cnt_t cap);
		logic [SUM_W-1:0] s;
		logic [SUM_W-1:0] w;
		s = SUM_W'(head) + SUM_W'(index);
		w = (s >= SUM_W'(cap)) ? s - SUM_W'(cap) : s;
		return (w >= SUM_W'(DEPTH)) ? '0 : PTR_W'(w);
	endfunction

endpackage

// ===== hdl/ocd_if.sv =====
// valid/ready channel interfaces for request and result transactions
// depends on ocd_pkg

interface ocd_req_if;
	import ocd_pkg::*;

	logic      valid;
	logic      ready;
	cmd_code_t cmd;
	idx_t      index;
	data_t     value;

	modport source (output valid, cmd, index, value, input ready);
	modport sink   (input valid, cmd, index, value, output ready);
endinterface

interface ocd_rsp_if;
	import ocd_pkg::*;

	logic                valid;
	logic                ready;
	data_t               read_value;
	logic [COUNT_W-1:0]  count;
	logic                is_empty;
	logic                is_full;
	logic                overwrote;
	logic [STATUS_W-1:0] status;

	modport source (output valid, read_value, count, is_empty, is_full, overwrote, status,
		input ready);
	modport sink   (input valid, read_value, count, is_empty, is_full, overwrote, status,
		output ready);
endinterface

// ===== hdl/ocd_slots.sv =====
// generic ram with one write port and one registered read port, used for the deque slots
// no dependencies; width and depth come in as parameters

module ocd_slots #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read; a write to the same address in the same cycle is passed through
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/ocd_step.sv =====
// next-state and result logic for one deque command
// depends on ocd_pkg

module ocd_step (
	input  ocd_pkg::cmd_code_t   cmd,
	input  ocd_pkg::idx_t        index,
	input  ocd_pkg::data_t       value,
	input  ocd_pkg::cnt_t        cap,
	input  ocd_pkg::ring_state_t cur,
	input  ocd_pkg::data_t       rd_data,
	output ocd_pkg::slot_wr_t    wr,
	output ocd_pkg::ring_state_t nxt,
	output ocd_pkg::result_t     res
);
	import ocd_pkg::*;

	ptr_t             pos;
	logic             in_range;
	logic             is_empty_now;
	logic             is_full_now;
	ptr_t             tail_next;
	ptr_t             head_prev;

	// logical index to physical slot
	assign pos = slot_pos(cur.head, index, cap);

	assign in_range     = SUM_W'(index) < SUM_W'(cur.count);
	assign is_empty_now = (cur.count == '0);
	assign is_full_now  = (cur.count >= cap);
	assign tail_next    = ring_next(cur.tail, cap);
	assign head_prev    = ring_prev(cur.head, cap);

	always_comb begin
		nxt            = cur;
		wr.en          = 1'b0;
		wr.addr        = pos;
		wr.data        = value;
		res.read_value = '0;
		res.overwrote  = 1'b0;
		res.status     = ST_OK;
		case (cmd)
			CMD_PUSH_BACK: begin
				wr.en = 1'b1;
				if (is_empty_now) begin
					wr.addr   = cur.head;
					nxt.tail  = cur.head;
					nxt.count = cnt_t'(1);
				end else begin
					wr.addr  = tail_next;
					nxt.tail = tail_next;
					if (is_full_now) begin
						nxt.head      = ring_next(cur.head, cap);
						res.overwrote = 1'b1;
					end else begin
						nxt.count = cur.count + cnt_t'(1);
					end
				end
			end
			CMD_PUSH_FRONT: begin
				wr.en = 1'b1;
				if (is_empty_now) begin
					wr.addr   = cur.head;
					nxt.tail  = cur.head;
					nxt.count = cnt_t'(1);
				end else begin
					wr.addr  = head_prev;
					nxt.head = head_prev;
					if (is_full_now) begin
						nxt.tail      = ring_prev(cur.tail, cap);
						res.overwrote = 1'b1;
					end else begin
						nxt.count = cur.count + cnt_t'(1);
					end
				end
			end
			CMD_POP_BACK: begin
				if (is_empty_now) begin
					res.status = ST_EMPTY_ERR;
				end else begin
					nxt.count = cur.count - cnt_t'(1);
					if (cur.count != cnt_t'(1))
						nxt.tail = ring_prev(cur.tail, cap);
				end
			end
			CMD_POP_FRONT: begin
				if (is_empty_now) begin
					res.status = ST_EMPTY_ERR;
				end else begin
					nxt.count = cur.count - cnt_t'(1);
					if (cur.count != cnt_t'(1))
						nxt.head = ring_next(cur.head, cap);
				end
			end
			CMD_READ_IDX: begin
				if (in_range)
					res.read_value = rd_data;
				else
					res.status = ST_RANGE_ERR;
			end
			CMD_WRITE_IDX: begin
				if (in_range)
					wr.en = 1'b1;
				else
					res.status = ST_RANGE_ERR;
			end
			CMD_CLEAR: begin
				nxt.count = '0;
				nxt.tail  = cur.head;
			end
			default: begin
			end
		endcase
		res.count    = nxt.count;
		res.is_empty = (nxt.count == '0);
		res.is_full  = (nxt.count == cap);
	end

endmodule

// ===== hdl/overwriting_circular_deque_core.sv =====
// top level of the overwriting circular deque: input register, ring state, result register
// depends on ocd_pkg, ocd_if, ocd_slots and ocd_step

// A ring of up to DEPTH slots used as a double-ended queue. Each request transaction carries
// one command (push back, push front, pop back, pop front, indexed read, indexed write, clear)
// and yields exactly one result transaction with the read value, the fill count, empty/full
// flags, an overwrite flag and a status code. A push on a full ring drops the element at the
// opposite end. Throughput is one transaction per cycle for every command while results are
// taken. A request is held in the input register, where a single pass of command logic updates
// the ring pointers and loads the result register, from which its result is presented.
// The slots sit in a ram with a registered read: the read address is formed while a request
// is accepted, from the head pointer that the command ahead of it leaves behind, so its read
// data is ready when an indexed read executes. The input only stalls while the result
// register holds a result that has not been taken. Writing cfg_wdata with cfg_we sets the
// capacity (zero acts as one, above DEPTH acts as DEPTH) and empties the ring; write it only
// while nothing is in flight. Slot contents are not cleared by reset; data from unused slots
// is never returned.

module overwriting_circular_deque_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  ocd_pkg::cfg_t       cfg_wdata,
	ocd_req_if.sink             req,
	ocd_rsp_if.source           rsp
);
	import ocd_pkg::*;

	// input stage
	logic        valid_s1;
	cmd_code_t   cmd_s1;
	idx_t        index_s1;
	data_t       value_s1;

	// ring state
	ring_state_t ring_q;
	cnt_t        cap_q;

	// result register
	logic        rsp_valid_q;
	result_t     rsp_q;

	// step logic signals
	ring_state_t ring_nxt;
	result_t     res;
	slot_wr_t    step_wr;
	slot_wr_t    slot_wr;
	ptr_t        head_ahead;
	ptr_t        rd_addr;
	data_t       rd_data;
	logic        advance;
	logic        req_take;

	// the input stage moves on whenever the result register is free or being emptied
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign req_take  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1   <= req.cmd;
			index_s1 <= req.index;
			value_s1 <= req.value;
		end
	end

	ocd_step u_step (
		.cmd     (cmd_s1),
		.index   (index_s1),
		.value   (value_s1),
		.cap     (cap_q),
		.cur     (ring_q),
		.rd_data (rd_data),
		.wr      (step_wr),
		.nxt     (ring_nxt),
		.res     (res)
	);

	// slot writes only when the command really executes
	always_comb begin
		slot_wr    = step_wr;
		slot_wr.en = step_wr.en && advance;
	end

	// read address for the incoming transaction, taken from the head it will see
	assign head_ahead = advance ? ring_nxt.head : ring_q.head;
	assign rd_addr    = slot_pos(head_ahead, req.index, cap_q);

	// read data is held while the transaction waits, no slot is written meanwhile
	ocd_slots #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (slot_wr.en),
		.wr_addr (slot_wr.addr),
		.wr_data (slot_wr.data),
		.rd_en   (req_take),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// ring pointers, count and capacity; a capacity write empties the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= '0;
			cap_q  <= eff_cap(cfg_t'(CAP_RESET));
		end else if (cfg_we) begin
			ring_q <= '0;
			cap_q  <= eff_cap(cfg_wdata);
		end else if (advance) begin
			ring_q <= ring_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_q.read_value;
	assign rsp.count      = COUNT_W'(rsp_q.count);
	assign rsp.is_empty   = rsp_q.is_empty;
	assign rsp.is_full    = rsp_q.is_full;
	assign rsp.overwrote  = rsp_q.overwrote;
	assign rsp.status     = rsp_q.status;

endmodule
